[src/lrae_pkg.sv]
// shared types, mode codes and color arithmetic for the led ring engine
package lrae_pkg;

   typedef enum logic [3:0] {
      MODE_NEUTRAL = 4'd0,
      MODE_LISTEN  = 4'd1,
      MODE_SPEAK   = 4'd2,
      MODE_THINK   = 4'd3,
      MODE_LOOK    = 4'd4,
      MODE_HAPPY   = 4'd5,
      MODE_ANGRY   = 4'd6,
      MODE_FOUND   = 4'd7,
      MODE_ERROR   = 4'd8,
      MODE_SLEEP   = 4'd9
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_LEVEL,
      ST_ODD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic do_phase;
      logic do_level;
      logic do_odd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic at_last;
   } status_type;

   localparam logic [7:0] SPEAK_ODD_SCALE = 8'd120;

   // x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x >> 8) + 17'd1;
      return s[15:8];
   endfunction

   function automatic logic [7:0] mul255(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] p;
      p = 16'(a) * 16'(b);
      return div255(p);
   endfunction

   function automatic logic [7:0] tri_step(input mode_type m);
      case (m)
         MODE_LISTEN: return 8'd3;
         MODE_SPEAK:  return 8'd10;
         MODE_LOOK:   return 8'd4;
         MODE_ANGRY:  return 8'd9;
         MODE_FOUND:  return 8'd8;
         MODE_SLEEP:  return 8'd1;
         default:     return 8'd2;
      endcase
   endfunction

   function automatic logic [7:0] tri_lo(input mode_type m);
      case (m)
         MODE_LISTEN: return 8'd10;
         MODE_SPEAK:  return 8'd25;
         MODE_LOOK:   return 8'd120;
         MODE_ANGRY:  return 8'd25;
         MODE_FOUND:  return 8'd25;
         MODE_SLEEP:  return 8'd0;
         default:     return 8'd4;
      endcase
   endfunction

   function automatic logic [7:0] tri_hi(input mode_type m);
      case (m)
         MODE_LISTEN: return 8'd55;
         MODE_SPEAK:  return 8'd95;
         MODE_LOOK:   return 8'd210;
         MODE_ANGRY:  return 8'd110;
         MODE_FOUND:  return 8'd120;
         MODE_SLEEP:  return 8'd14;
         default:     return 8'd18;
      endcase
   endfunction

   // hue to rgb at saturation 230, value 85
   function automatic logic [23:0] hsv_rainbow(input logic [7:0] h);
      logic [2:0]  sector;
      logic [7:0]  base;
      logic [7:0]  rem;
      logic [15:0] sq;
      logic [15:0] st;
      logic [7:0]  p;
      logic [7:0]  q;
      logic [7:0]  t;
      logic [7:0]  v;
      if (h < 8'd43) begin
         sector = 3'd0; base = 8'd0;
      end else if (h < 8'd86) begin
         sector = 3'd1; base = 8'd43;
      end else if (h < 8'd129) begin
         sector = 3'd2; base = 8'd86;
      end else if (h < 8'd172) begin
         sector = 3'd3; base = 8'd129;
      end else if (h < 8'd215) begin
         sector = 3'd4; base = 8'd172;
      end else begin
         sector = 3'd5; base = 8'd215;
      end
      rem = 8'((h - base) * 8'd6);
      v = 8'd85;
      p = 8'((16'd85 * 16'd25) >> 8);
      sq = 16'(16'd230 * 16'(rem));
      st = 16'(16'd230 * 16'(8'd255 - rem));
      q = 8'((16'd85 * 16'(8'd255 - sq[15:8])) >> 8);
      t = 8'((16'd85 * 16'(8'd255 - st[15:8])) >> 8);
      case (sector)
         3'd1:    return {q, v, p};
         3'd2:    return {p, v, t};
         3'd3:    return {p, q, v};
         3'd4:    return {t, p, v};
         3'd5:    return {v, p, q};
         default: return {v, t, p};
      endcase
   endfunction

endpackage

[src/lrae_req_if.sv]
// request channel: action, mode and dark flag
interface lrae_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] mode;
   logic       dark;
   modport source (output valid, output action, output mode, output dark, input ready);
   modport sink (input valid, input action, input mode, input dark, output ready);
endinterface

[src/lrae_rsp_if.sv]
// response channel: one led color word
interface lrae_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] led_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last;
   modport source (output valid, output led_index, output red, output green, output blue,
      output last, input ready);
   modport sink (input valid, input led_index, input red, input green, input blue,
      input last, output ready);
endinterface

[src/lrae_ctrl.sv]
// sequencer for frame setup and per-led emission
module lrae_ctrl
   import lrae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PHASE;
         ST_PHASE: state_in = ST_LEVEL;
         ST_LEVEL: state_in = ST_ODD;
         ST_ODD:   state_in = ST_EMIT;
         ST_EMIT:  if (status.slot_free && status.at_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PHASE: cmd.do_phase = 1'b1;
         ST_LEVEL: cmd.do_level = 1'b1;
         ST_ODD:   cmd.do_odd = 1'b1;
         ST_EMIT:  cmd.emit = status.slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_PHASE) else $error("accept did not start setup");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == ST_EMIT) else $error("emit outside emit state");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.at_last) |=> state_ff == ST_IDLE) else $error("frame did not end");

endmodule

[src/lrae_datapath.sv]
// frame counters, pattern levels and per-led color output register
module lrae_datapath
   import lrae_pkg::*;
#(
   parameter int LED_COUNT = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_action,
   input  logic [3:0] req_mode,
   input  logic       req_dark,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_led_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_last
);

   localparam int IW = $clog2(LED_COUNT);
   localparam logic [IW:0] N = (IW+1)'(LED_COUNT);
   localparam logic [IW-1:0] LAST_IDX = IW'(LED_COUNT - 1);
   localparam logic [IW-1:0] HALF = IW'(LED_COUNT / 2);

   logic [31:0]   f_ff;
   mode_type      mode_ff;
   logic          dark_ff;
   logic [1:0]    ph3_ff;
   logic [IW-1:0] head2_ff;
   logic [IW-1:0] sw3_ff;
   logic [1:0]    f4m3_ff;
   logic [7:0]    t_ff;
   logic [7:0]    v_ff;
   logic [7:0]    vodd_ff;
   logic [IW-1:0] idx_ff;
   logic [1:0]    imod3_ff;
   logic          valid_ff;
   logic [3:0]    oidx_ff;
   logic [7:0]    r_ff;
   logic [7:0]    g_ff;
   logic [7:0]    b_ff;
   logic          last_ff;

   logic [7:0]    x;
   logic [7:0]    r_in;
   logic [7:0]    g_in;
   logic [7:0]    b_in;
   logic [7:0]    vv;
   logic [7:0]    vt;
   logic [IW:0]   gap;
   logic [IW:0]   opp;
   logic [IW-1:0] opp_idx;
   logic [2:0]    msum;
   logic [23:0]   rgb;
   logic [7:0]    hue;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
      return (a == LAST_IDX) ? '0 : a + 1'b1;
   endfunction

   assign status.slot_free = !valid_ff || rsp_ready;
   assign status.at_last = idx_ff == LAST_IDX;

   always_comb begin
      x = 8'(f_ff[7:0] * tri_step(mode_ff));
   end

   always_comb begin
      opp = {1'b0, sw3_ff} + (IW+1)'(HALF);
      if (opp >= N) opp = opp - N;
      opp_idx = opp[IW-1:0];
      gap = {1'b0, idx_ff} + N - {1'b0, head2_ff};
      if (gap >= N) gap = gap - N;
      msum = {1'b0, imod3_ff} + {1'b0, f4m3_ff};
      hue = 8'(f_ff[7:0] * 8'd3) + 8'(16'(idx_ff) * 16'd21);
      rgb = hsv_rainbow(hue);
      vv = idx_ff[0] ? vodd_ff : v_ff;
      if (gap == '0) vt = 8'd95;
      else if (gap == (IW+1)'(1) || gap == N - (IW+1)'(1)) vt = 8'd42;
      else if (gap == (IW+1)'(2) || gap == N - (IW+1)'(2)) vt = 8'd14;
      else vt = 8'd2;
      r_in = '0;
      g_in = '0;
      b_in = '0;
      case (mode_ff)
         MODE_LISTEN: begin
            g_in = mul255(8'd80, v_ff);
            b_in = v_ff;
         end
         MODE_SPEAK: begin
            r_in = mul255(8'd60, vv);
            g_in = vv;
            b_in = mul255(8'd120, vv);
         end
         MODE_THINK: begin
            g_in = mul255(8'd120, vt);
            b_in = vt;
         end
         MODE_LOOK: begin
            r_in = (idx_ff == sw3_ff || idx_ff == opp_idx) ? 8'd245 : v_ff;
            g_in = r_in;
            b_in = r_in;
         end
         MODE_HAPPY: begin
            r_in = rgb[23:16];
            g_in = rgb[15:8];
            b_in = rgb[7:0];
         end
         MODE_ANGRY: r_in = (idx_ff == sw3_ff) ? 8'd130 : v_ff;
         MODE_FOUND: begin
            if (msum == 3'd0 || msum == 3'd3) begin
               r_in = v_ff;
               g_in = mul255(8'd220, v_ff);
            end else begin
               r_in = mul255(8'd30, v_ff);
               g_in = mul255(8'd70, v_ff);
            end
         end
         MODE_ERROR: begin
            if (!f_ff[3]) begin
               r_in = 8'd110;
               g_in = 8'd12;
            end
         end
         MODE_SLEEP: b_in = dark_ff ? 8'd0 : v_ff;
         default: b_in = v_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff <= '0;
         mode_ff <= MODE_NEUTRAL;
         ph3_ff <= '0;
         head2_ff <= '0;
         sw3_ff <= '0;
         f4m3_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            dark_ff <= req_dark;
            idx_ff <= '0;
            imod3_ff <= '0;
            if (req_action) begin
               mode_ff <= (req_mode <= MODE_SLEEP) ? mode_type'(req_mode) : MODE_NEUTRAL;
               f_ff <= 32'd1;
               ph3_ff <= 2'd1;
               head2_ff <= '0;
               sw3_ff <= '0;
               f4m3_ff <= '0;
            end else if (f_ff == '1) begin
               f_ff <= '0;
               ph3_ff <= '0;
               head2_ff <= '0;
               sw3_ff <= '0;
               f4m3_ff <= '0;
            end else begin
               f_ff <= f_ff + 32'd1;
               if (f_ff[0]) head2_ff <= wrap_inc(head2_ff);
               if (ph3_ff == 2'd2) begin
                  ph3_ff <= '0;
                  sw3_ff <= wrap_inc(sw3_ff);
               end else begin
                  ph3_ff <= ph3_ff + 2'd1;
               end
               if (f_ff[1:0] == 2'd3) f4m3_ff <= (f4m3_ff == 2'd2) ? 2'd0 : f4m3_ff + 2'd1;
            end
         end
         if (cmd.do_phase) begin
            t_ff <= x[7] ? 8'((8'd255 - x) << 1) : 8'(x << 1);
         end
         if (cmd.do_level) begin
            v_ff <= tri_lo(mode_ff) + div255(16'(tri_hi(mode_ff) - tri_lo(mode_ff)) * 16'(t_ff));
         end
         if (cmd.do_odd) begin
            vodd_ff <= mul255(v_ff, SPEAK_ODD_SCALE);
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
            oidx_ff <= 4'(idx_ff);
            r_ff <= r_in;
            g_ff <= g_in;
            b_ff <= b_in;
            last_ff <= idx_ff == LAST_IDX;
            idx_ff <= idx_ff + 1'b1;
            imod3_ff <= (imod3_ff == 2'd2) ? 2'd0 : imod3_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_led_index = oidx_ff;
   assign rsp_red = r_ff;
   assign rsp_green = g_ff;
   assign rsp_blue = b_ff;
   assign rsp_last = last_ff;

endmodule

[src/led_ring_animation_engine.sv]
// top level of the led ring animation engine
// setup: an accepted request word first runs the phase, level and odd
// states, which set the pattern level; the emit state then sends one
// color word per cycle while the response side is ready
// reset: synchronous, clears frame counter to zero and mode to neutral
module led_ring_animation_engine
   import lrae_pkg::*;
#(
   parameter int LED_COUNT = 12
) (
   input  logic clock,
   input  logic reset,
   lrae_req_if.sink   req_ch,
   lrae_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   lrae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrae_datapath #(.LED_COUNT(LED_COUNT)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_ch.action),
      .req_mode      (req_ch.mode),
      .req_dark      (req_ch.dark),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_led_index (rsp_ch.led_index),
      .rsp_red       (rsp_ch.red),
      .rsp_green     (rsp_ch.green),
      .rsp_blue      (rsp_ch.blue),
      .rsp_last      (rsp_ch.last)
   );

endmodule

[tb/led_ring_animation_engine_tb.sv]
// self-checking testbench for the led ring animation engine
module led_ring_animation_engine_tb;
   import lrae_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEDS = 12;

   typedef struct packed {
      logic [3:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } color_word_type;

   class color_scoreboard;
      color_word_type pending[$];
      logic [31:0] frame;
      mode_type    mode;
      int          errors;

      function new();
         frame = 0;
         mode = MODE_NEUTRAL;
         errors = 0;
      endfunction

      function automatic int unsigned tri_wave(int unsigned x, int unsigned lo,
            int unsigned hi);
         int unsigned ph;
         int unsigned t;
         ph = x & 255;
         t = (ph < 128) ? ph * 2 : (255 - ph) * 2;
         return (lo + ((hi - lo) * t) / 255) & 255;
      endfunction

      function automatic int unsigned scale(int unsigned a, int unsigned b);
         return ((a & 255) * (b & 255)) / 255;
      endfunction

      function automatic logic [23:0] rainbow(int unsigned h);
         int unsigned sector, rem, p, q, t, v, s;
         v = 85;
         s = 230;
         sector = h / 43;
         rem = ((h - sector * 43) * 6) & 255;
         p = ((v * (255 - s)) >> 8) & 255;
         q = ((v * (255 - ((s * rem) >> 8))) >> 8) & 255;
         t = ((v * (255 - ((s * (255 - rem)) >> 8))) >> 8) & 255;
         case (sector)
            1: return {8'(q), 8'(v), 8'(p)};
            2: return {8'(p), 8'(v), 8'(t)};
            3: return {8'(p), 8'(q), 8'(v)};
            4: return {8'(t), 8'(p), 8'(v)};
            5: return {8'(v), 8'(p), 8'(q)};
            default: return {8'(v), 8'(t), 8'(p)};
         endcase
      endfunction

      function automatic logic [23:0] led_color(int unsigned i, logic dark);
         int unsigned f, n, v, r, g, b, head, gap, sw;
         f = frame;
         n = LEDS;
         r = 0; g = 0; b = 0;
         case (mode)
            MODE_LISTEN: begin
               v = tri_wave(f * 3, 10, 55);
               g = scale(80, v); b = v;
            end
            MODE_SPEAK: begin
               v = tri_wave(f * 10, 25, 95);
               if (i % 2 != 0) v = scale(v, 120);
               r = scale(60, v); g = v; b = scale(120, v);
            end
            MODE_THINK: begin
               head = (f / 2) % n;
               gap = (i + n - head) % n;
               v = 2;
               if (gap == 0) v = 95;
               else if (gap == 1 || gap == n - 1) v = 42;
               else if (gap == 2 || gap == n - 2) v = 14;
               g = scale(120, v); b = v;
            end
            MODE_LOOK: begin
               sw = (f / 3) % n;
               v = tri_wave(f * 4, 120, 210);
               if (i == sw || i == (sw + n / 2) % n) v = 245;
               r = v; g = v; b = v;
            end
            MODE_HAPPY: return rainbow((f * 3 + i * 21) & 255);
            MODE_ANGRY: begin
               v = tri_wave(f * 9, 25, 110);
               if (i == (f / 3) % n) v = 130;
               r = v;
            end
            MODE_FOUND: begin
               v = tri_wave(f * 8, 25, 120);
               if ((i + f / 4) % 3 == 0) begin
                  r = v; g = scale(220, v);
               end else begin
                  r = scale(30, v); g = scale(70, v);
               end
            end
            MODE_ERROR: begin
               if (((f / 8) % 2) == 0) begin
                  r = 110; g = 12;
               end
            end
            MODE_SLEEP: if (!dark) b = tri_wave(f, 0, 14);
            default: b = tri_wave(f * 2, 4, 18);
         endcase
         return {8'(r), 8'(g), 8'(b)};
      endfunction

      function void note_request(logic action, logic [3:0] m, logic dark);
         color_word_type w;
         logic [23:0] c;
         if (action) begin
            mode = (m <= 4'd9) ? mode_type'(m) : MODE_NEUTRAL;
            frame = 1;
         end else begin
            frame = frame + 1;
         end
         for (int i = 0; i < LEDS; i++) begin
            c = led_color(i, dark);
            w.led_index = 4'(i);
            {w.red, w.green, w.blue} = c;
            w.last = (i == LEDS - 1);
            pending.push_back(w);
         end
      endfunction

      function void check_color(color_word_type got);
         color_word_type e;
         if (pending.size() == 0) begin
            $error("unexpected color word %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.led_index !== e.led_index) begin
            $error("led_index expected %0d actual %0d", e.led_index, got.led_index); errors++;
         end
         if (got.red !== e.red) begin
            $error("red expected %0d actual %0d", e.red, got.red); errors++;
         end
         if (got.green !== e.green) begin
            $error("green expected %0d actual %0d", e.green, got.green); errors++;
         end
         if (got.blue !== e.blue) begin
            $error("blue expected %0d actual %0d", e.blue, got.blue); errors++;
         end
         if (got.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   req_idle_pct = 34;
   int   rsp_idle_pct = 66;
   color_scoreboard frames = new();

   lrae_req_if req_ch();
   lrae_rsp_if rsp_ch();

   led_ring_animation_engine #(.LED_COUNT(LEDS)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.action = 0;
      req_ch.mode = 0;
      req_ch.dark = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready)
            frames.check_color({rsp_ch.led_index, rsp_ch.red, rsp_ch.green, rsp_ch.blue,
               rsp_ch.last});
      end
   end

   task automatic send_word(logic action, logic [3:0] m, logic dark);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.action <= action;
      req_ch.mode <= m;
      req_ch.dark <= dark;
      do @(posedge clock); while (!req_ch.ready);
      frames.note_request(action, m, dark);
   endtask

   task automatic random_words(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0)
            send_word(1'b1, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else
            send_word($urandom_range(15) == 0, 4'($urandom_range(9)),
               1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // ticks from reset, then every mode and unknown codes
      send_word(1'b0, 4'd0, 1'b0);
      send_word(1'b0, 4'd15, 1'b1);
      for (int m = 0; m < 16; m++) send_word(1'b1, 4'(m), m[0]);
      send_word(1'b1, 4'd9, 1'b1);
      send_word(1'b0, 4'd9, 1'b1);
      send_word(1'b0, 4'd3, 1'b0);
      send_word(1'b1, 4'd8, 1'b1);
      send_word(1'b0, 4'd0, 1'b1);
      random_words(80);
      req_idle_pct = 66;
      rsp_idle_pct = 34;
      random_words(80);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_words(80);
      // short runs in every mode
      for (int m = 0; m < 10; m++) begin
         send_word(1'b1, 4'(m), 1'($urandom_range(1)));
         repeat (4) send_word(1'b0, 4'($urandom_range(15)), 1'($urandom_range(1)));
      end
      req_ch.valid <= 0;
      while (frames.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (frames.errors == 0)
         $display("led_ring_animation_engine verification clean");
      else
         $display("led_ring_animation_engine verification failed");
      $finish;
   end

   initial begin
      #10ms;
      $display("led_ring_animation_engine verification failed");
      $finish;
   end

endmodule
